// ===== hdl/srr45_pkg.sv =====
// ============================================================================
// srr45_pkg - shared types and constants for the square ring rotate mapper
// Image size limits, configuration register codes and the pipeline tag.
// ============================================================================
`default_nettype none

package srr45_pkg;

    // Largest image side the mapper supports.
    localparam int MAX_SIDE = 4095;

    // Payload widths.
    localparam int COORD_W = 12;                 // pixel column / row
    localparam int HALF_W  = 11;                 // half_size register
    localparam int STEPS_W = 3;                  // rotation_steps register
    localparam int RING_W  = 11;                 // ring radius r
    localparam int PIDX_W  = 14;                 // perimeter index 0..8r-1
    localparam int OFS_W   = 13;                 // signed offset from centre

    // Half-size clamp so that 2*half+1 never exceeds MAX_SIDE.
    localparam logic [HALF_W-1:0] HALF_MAX = HALF_W'((MAX_SIDE - 1) / 2);

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_SIZE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_ROT_STEPS = CFG_IDX_W'(1);

    localparam logic [STEPS_W-1:0] STEPS_RESET = STEPS_W'(1);

    // Control that travels alongside each coordinate.
    typedef struct packed {
        logic valid;
        logic outside;
    } t_tag;

endpackage : srr45_pkg

`default_nettype wire

// ===== hdl/srr45_ring_walk.sv =====
// ============================================================================
// srr45_ring_walk - perimeter rotation and index-to-offset conversion
// Two register stages: rewind the perimeter index by steps*r with wrap,
// then turn the index back into a (dx,dy) offset on the same ring.
// ============================================================================
`default_nettype none

module srr45_ring_walk (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  srr45_pkg::t_tag                      i_tag,
    input  wire [srr45_pkg::PIDX_W-1:0]          i_pidx,
    input  wire [srr45_pkg::RING_W-1:0]          i_ring,
    input  wire [srr45_pkg::STEPS_W-1:0]         i_steps,
    output srr45_pkg::t_tag                      o_tag,
    output logic signed [srr45_pkg::OFS_W-1:0]   o_sx,
    output logic signed [srr45_pkg::OFS_W-1:0]   o_sy
);
    import srr45_pkg::*;

    // ---- stage A: q = p - steps*r, wrapped into 0..8r-1 -------------------
    logic [PIDX_W-1:0]     w_back;
    logic signed [15:0]    w_q;
    logic signed [15:0]    w_qw;

    t_tag                  r_a_tag;
    logic [PIDX_W-1:0]     r_a_q;
    logic [RING_W-1:0]     r_a_ring;

    assign w_back = {{(PIDX_W-RING_W){1'b0}}, i_ring} * {{(PIDX_W-STEPS_W){1'b0}}, i_steps};
    assign w_q    = $signed({2'b00, i_pidx}) - $signed({2'b00, w_back});
    assign w_qw   = (w_q < 0) ? w_q + $signed({2'b00, i_ring, 3'b000}) : w_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_tag <= '0;
        end else begin
            r_a_tag <= i_tag;
        end
        r_a_q    <= w_qw[PIDX_W-1:0];
        r_a_ring <= i_ring;
    end

    // ---- stage B: perimeter index back to an offset -----------------------
    logic signed [15:0] w_qs;
    logic signed [15:0] w_rs;
    logic signed [15:0] w_r2;
    logic signed [15:0] w_r3;
    logic signed [15:0] w_r4;
    logic signed [15:0] w_r5;
    logic signed [15:0] w_r6;
    logic signed [15:0] w_r7;
    logic signed [15:0] n_sx;
    logic signed [15:0] n_sy;

    assign w_qs = $signed({2'b00, r_a_q});
    assign w_rs = $signed({5'b00000, r_a_ring});
    assign w_r2 = w_rs <<< 1;
    assign w_r4 = w_rs <<< 2;
    assign w_r3 = w_r2 + w_rs;
    assign w_r5 = w_r4 + w_rs;
    assign w_r6 = w_r4 + w_r2;
    assign w_r7 = w_r6 + w_rs;

    always_comb begin
        priority if (w_qs <= w_r2) begin          // top edge
            n_sx = w_qs - w_rs;
            n_sy = -w_rs;
        end else if (w_qs <= w_r4) begin          // right edge
            n_sx = w_rs;
            n_sy = w_qs - w_r3;
        end else if (w_qs <= w_r6) begin          // bottom edge
            n_sx = w_r5 - w_qs;
            n_sy = w_rs;
        end else begin                            // left edge
            n_sx = -w_rs;
            n_sy = w_r7 - w_qs;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_tag <= '0;
        end else begin
            o_tag <= r_a_tag;
        end
        o_sx <= n_sx[OFS_W-1:0];
        o_sy <= n_sy[OFS_W-1:0];
    end

endmodule : srr45_ring_walk

`default_nettype wire

// ===== hdl/square_ring_rotate45_mapper.sv =====
// ============================================================================
// square_ring_rotate45_mapper - source coordinate for a 45 degree ring rotation
// Maps each output pixel coordinate to the input pixel it is copied from.
// ============================================================================
//
// One transaction per clock: a coordinate is taken at every edge where start
// is high (busy is tied low, the pipeline never refuses), and its result
// appears on the o_source_* ports with o_valid high for exactly one cycle
// from the output register. Results leave in the order the coordinates came
// in. The pipeline registers these steps in order: offset and bounds check,
// ring radius and perimeter index, rewind along the perimeter, index back to
// an offset, and the final add of the centre. The receiver cannot stall, so
// nothing is held back. Write half_size and rotation_steps only while no
// transaction is in flight; the image side is 2*half_size+1 and a coordinate
// at or beyond the side returns zeros with o_outside set.
`default_nettype none

module square_ring_rotate45_mapper (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    // command channel
    input  wire                                  start,
    output logic                                 busy,
    input  wire [srr45_pkg::COORD_W-1:0]         i_dest_col,
    input  wire [srr45_pkg::COORD_W-1:0]         i_dest_row,
    // result channel
    output logic                                 o_valid,
    output logic [srr45_pkg::COORD_W-1:0]        o_source_col,
    output logic [srr45_pkg::COORD_W-1:0]        o_source_row,
    output logic                                 o_outside,
    // configuration writes
    input  wire                                  i_cfg_we,
    input  wire [srr45_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire [srr45_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import srr45_pkg::*;

    // ---- configuration registers ------------------------------------------
    logic [HALF_W-1:0]  r_half;
    logic [STEPS_W-1:0] r_steps;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half  <= '0;
            r_steps <= STEPS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_HALF_SIZE: r_half  <= (i_cfg_data[HALF_W-1:0] > HALF_MAX)
                                          ? HALF_MAX : i_cfg_data[HALF_W-1:0];
                CFG_ROT_STEPS: r_steps <= i_cfg_data[STEPS_W-1:0];
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    // ---- stage 1: bounds check and offset from centre ---------------------
    logic [COORD_W-1:0]     w_side;
    t_tag                   r_s1_tag;
    logic signed [OFS_W-1:0] r_s1_dx;
    logic signed [OFS_W-1:0] r_s1_dy;

    assign w_side = {r_half, 1'b1};             // 2*half+1

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_tag.valid <= 1'b0;
        end else begin
            r_s1_tag.valid <= start & ~busy;
        end
        r_s1_tag.outside <= (i_dest_col >= w_side) || (i_dest_row >= w_side);
        r_s1_dx <= $signed({1'b0, i_dest_col}) - $signed({2'b00, r_half});
        r_s1_dy <= $signed({1'b0, i_dest_row}) - $signed({2'b00, r_half});
    end

    // ---- stage 2: ring radius and clockwise perimeter index ---------------
    // Index starts at the ring's top-left corner: top edge dx+r, right edge
    // 3r+dy, bottom edge 5r-dx, left edge 7r-dy. The centre falls out as 0.
    logic [OFS_W-1:0]    w_adx;
    logic [OFS_W-1:0]    w_ady;
    logic [OFS_W-1:0]    w_rmax;
    logic signed [15:0]  w_dx;
    logic signed [15:0]  w_dy;
    logic signed [15:0]  w_r;
    logic signed [15:0]  n_p;

    t_tag                r_s2_tag;
    logic [PIDX_W-1:0]   r_s2_p;
    logic [RING_W-1:0]   r_s2_ring;

    assign w_adx  = r_s1_dx[OFS_W-1] ? OFS_W'(-r_s1_dx) : r_s1_dx;
    assign w_ady  = r_s1_dy[OFS_W-1] ? OFS_W'(-r_s1_dy) : r_s1_dy;
    assign w_rmax = (w_adx > w_ady) ? w_adx : w_ady;
    assign w_dx   = 16'(r_s1_dx);
    assign w_dy   = 16'(r_s1_dy);
    assign w_r    = $signed({5'b00000, w_rmax[RING_W-1:0]});

    always_comb begin
        priority if (w_dy == -w_r) begin
            n_p = w_dx + w_r;
        end else if (w_dx == w_r) begin
            n_p = (w_r <<< 1) + w_r + w_dy;
        end else if (w_dy == w_r) begin
            n_p = (w_r <<< 2) + w_r - w_dx;
        end else begin
            n_p = (w_r <<< 3) - w_r - w_dy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_tag <= '0;
        end else begin
            r_s2_tag <= r_s1_tag;
        end
        r_s2_p    <= n_p[PIDX_W-1:0];
        r_s2_ring <= w_rmax[RING_W-1:0];
    end

    // ---- stages 3 and 4: rotate along the ring ----------------------------
    t_tag                    w_s4_tag;
    logic signed [OFS_W-1:0] w_s4_sx;
    logic signed [OFS_W-1:0] w_s4_sy;

    srr45_ring_walk u_walk (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (r_s2_tag),
        .i_pidx  (r_s2_p),
        .i_ring  (r_s2_ring),
        .i_steps (r_steps),
        .o_tag   (w_s4_tag),
        .o_sx    (w_s4_sx),
        .o_sy    (w_s4_sy)
    );

    // ---- stage 5: add centre back, zero when outside ----------------------
    logic signed [OFS_W-1:0] w_col;
    logic signed [OFS_W-1:0] w_row;

    assign w_col = $signed({2'b00, r_half}) + w_s4_sx;
    assign w_row = $signed({2'b00, r_half}) + w_s4_sy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= w_s4_tag.valid;
        end
        o_outside    <= w_s4_tag.outside;
        o_source_col <= w_s4_tag.outside ? '0 : w_col[COORD_W-1:0];
        o_source_row <= w_s4_tag.outside ? '0 : w_row[COORD_W-1:0];
    end

`ifndef SYNTHESIS
    // every accepted transaction produces a result at the pipeline output
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##5 o_valid)
        else $error("accepted transaction produced no result");

    // results only for accepted transactions
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(i_rst_n, 5)) |-> $past(start && !busy, 5))
        else $error("result without an accepted transaction");

    // out-of-image coordinates come back as zeros
    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_outside) |-> (o_source_col == '0 && o_source_row == '0))
        else $error("outside result carries nonzero coordinates");

    // reset flushes the pipeline
    a_reset_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result strobe right after reset");
`endif

endmodule : square_ring_rotate45_mapper

`default_nettype wire
